// ----- sv/scgm_pkg.sv -----
`default_nettype none
// Shared types and constants of the sprite clip group merge block.
package scgm_pkg;

  typedef enum logic [2:0] {
    CMD_START  = 3'd0,
    CMD_SEG    = 3'd1,
    CMD_COL    = 3'd2,
    CMD_FINISH = 3'd3,
    CMD_READ   = 3'd4
  } cmd_e;

  localparam logic RES_BOUNDS = 1'b0;
  localparam logic RES_COLUMN = 1'b1;

  localparam logic [14:0] VIEW_HEIGHT_RST = 15'd200;

  // Group start counter width; tag zero marks a swept entry.
  localparam int EPOCH_W = 4;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef logic [14:0] cfg_data_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [10:0]        seg_left;
    logic [11:0]        seg_right;
    logic signed [31:0] depth_start;
    logic signed [31:0] depth_end;
    logic               is_fake;
    logic [1:0]         sil_bits;
    logic [10:0]        column;
    logic signed [15:0] col_top;
    logic signed [15:0] col_bottom;
  } in_item_t;

  typedef struct packed {
    logic               result_kind;
    logic [10:0]        group_left;
    logic [11:0]        group_right;
    logic signed [31:0] near_depth;
    logic signed [31:0] far_depth;
    logic signed [15:0] top_clip;
    logic signed [15:0] bottom_clip;
  } out_item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic signed [15:0] top;
    logic signed [15:0] bottom;
  } col_ent_t;

endpackage
`default_nettype wire

// ----- sv/scgm_chan_if.sv -----
`default_nettype none
// Valid/ready channel interface carrying one payload per transfer.
interface scgm_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/sprite_clip_group_merge_unit.sv -----
`default_nettype none
// Top level of the sprite clip group merge block.
//
//   channel  dir  payload               transfer when
//   in_if    in   scgm_pkg::in_item_t   in_if.valid && in_if.ready
//   out_if   out  scgm_pkg::out_item_t  out_if.valid && out_if.ready
//   cfg_if   in   view_height (15 bits) cfg_if.valid && cfg_if.ready
//
// Items are accepted one per cycle while in_if.ready is high; stage 1 feeds out_item_r.
// The column store is read at the transfer edge and written as the item leaves stage 1,
// with the last write forwarded so back-to-back items on one column merge correctly.
// After reset, and after every fifteenth group start, a clearing sweep of all MAX_WIDTH
// entries retags the column store; in_if.ready is low during the sweep and, for a group
// start that triggers one, also in the cycle that start spends in stage 1.
// A result waiting in the output register stalls only items that produce a result.
module sprite_clip_group_merge_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input wire logic   clk,
  input wire logic   rst_n,
  scgm_chan_if.sink   in_if,
  scgm_chan_if.source out_if,
  scgm_chan_if.sink   cfg_if
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [AW-1:0] SWEEP_LAST = AW'(MAX_WIDTH - 1);

  // Stage 1 and memory read data.
  logic                          s1_vld_r;
  scgm_pkg::in_item_t            s1_item_r;
  scgm_pkg::col_ent_t            rd_ent;

  logic [14:0]                   view_height_r;
  logic [scgm_pkg::EPOCH_W-1:0]  epoch_r;
  logic                          sweep_r;
  logic [AW-1:0]                 sweep_cnt_r;

  logic [10:0]                   span_left_r;
  logic [11:0]                   span_right_r;
  logic signed [31:0]            depth_near_r;
  logic signed [31:0]            depth_far_r;
  logic                          group_empty_r;
  logic [10:0]                   cur_left_r;
  logic [11:0]                   cur_right_r;
  logic                          cur_fake_r;
  logic [1:0]                    cur_sil_r;

  logic                          fwd_vld_r;
  logic [AW-1:0]                 fwd_addr_r;
  scgm_pkg::col_ent_t            fwd_ent_r;

  logic                          out_vld_r;
  scgm_pkg::out_item_t           out_item_r;
  scgm_pkg::out_item_t           out_item_nxt;

  scgm_pkg::cmd_e                s1_cmd;
  logic                          s1_res;
  logic                          s1_adv;
  logic                          s1_stall;
  logic                          wrap;
  logic                          in_acc;
  logic [AW-1:0]                 s1_addr;
  logic                          col_in_mem;
  scgm_pkg::col_ent_t            ent;
  logic                          ent_hit;
  logic signed [15:0]            base_top;
  logic signed [15:0]            base_bot;
  logic signed [15:0]            vh_ext;
  scgm_pkg::col_ent_t            mrg_ent;
  logic                          col_hit;
  logic                          mrg_wr;
  logic signed [31:0]            seg_lo;
  logic signed [31:0]            seg_hi;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  scgm_pkg::col_ent_t            mem_wdata;

  always_comb begin
    s1_cmd     = scgm_pkg::cmd_e'(s1_item_r.cmd);
    s1_res     = s1_vld_r && (s1_cmd == scgm_pkg::CMD_FINISH ||
                              s1_cmd == scgm_pkg::CMD_READ);
    s1_adv     = s1_vld_r && (!s1_res || !out_vld_r || out_if.ready);
    s1_stall   = s1_vld_r && !s1_adv;
    wrap       = s1_vld_r && s1_cmd == scgm_pkg::CMD_START &&
                 epoch_r == scgm_pkg::EPOCH_LAST;
    in_if.ready = !sweep_r && !wrap && !s1_stall;
    in_acc     = in_if.valid && in_if.ready;

    s1_addr    = AW'(s1_item_r.column);
    col_in_mem = int'(s1_item_r.column) < MAX_WIDTH;
    ent        = (fwd_vld_r && fwd_addr_r == s1_addr) ? fwd_ent_r : rd_ent;
    // An entry tagged by an earlier group reads as a fresh column.
    ent_hit    = ent.tag == epoch_r;
    vh_ext     = signed'({1'b0, view_height_r});
    base_top   = ent_hit ? ent.top : '0;
    base_bot   = ent_hit ? ent.bottom : vh_ext;

    mrg_ent.tag    = epoch_r;
    mrg_ent.top    = (cur_sil_r[1] && base_top < s1_item_r.col_top) ?
                     s1_item_r.col_top : base_top;
    mrg_ent.bottom = (cur_sil_r[0] && s1_item_r.col_bottom < base_bot) ?
                     s1_item_r.col_bottom : base_bot;
    col_hit = !cur_fake_r && s1_item_r.column >= cur_left_r &&
              {1'b0, s1_item_r.column} < cur_right_r && col_in_mem;
    mrg_wr  = s1_adv && s1_cmd == scgm_pkg::CMD_COL && col_hit;

    mem_we    = mrg_wr || sweep_r;
    mem_waddr = sweep_r ? sweep_cnt_r : s1_addr;
    mem_wdata = sweep_r ? '0 : mrg_ent;

    seg_lo = (s1_item_r.depth_end < s1_item_r.depth_start) ?
             s1_item_r.depth_end : s1_item_r.depth_start;
    seg_hi = (s1_item_r.depth_start < s1_item_r.depth_end) ?
             s1_item_r.depth_end : s1_item_r.depth_start;

    out_item_nxt = '0;
    if (s1_cmd == scgm_pkg::CMD_READ) begin
      out_item_nxt.result_kind = scgm_pkg::RES_COLUMN;
      out_item_nxt.top_clip    = col_in_mem ? base_top : '0;
      out_item_nxt.bottom_clip = col_in_mem ? base_bot : vh_ext;
    end else begin
      out_item_nxt.result_kind = scgm_pkg::RES_BOUNDS;
      out_item_nxt.group_left  = span_left_r;
      out_item_nxt.group_right = span_right_r;
      out_item_nxt.near_depth  = depth_near_r;
      out_item_nxt.far_depth   = depth_far_r;
    end
  end

  scgm_col_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (AW)
  ) u_col_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (in_acc),
    .rd_addr (AW'(in_if.data.column)),
    .rd_data (rd_ent)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r      <= 1'b0;
      view_height_r <= scgm_pkg::VIEW_HEIGHT_RST;
      epoch_r       <= scgm_pkg::EPOCH_FIRST;
      sweep_r       <= 1'b1;
      sweep_cnt_r   <= '0;
      span_left_r   <= '0;
      span_right_r  <= '0;
      depth_near_r  <= '0;
      depth_far_r   <= '0;
      group_empty_r <= 1'b1;
      cur_left_r    <= '0;
      cur_right_r   <= '0;
      cur_fake_r    <= 1'b1;
      cur_sil_r     <= '0;
      fwd_vld_r     <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_if.valid) begin
        view_height_r <= cfg_if.data;
      end

      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end

      if (sweep_r) begin
        sweep_cnt_r <= sweep_cnt_r + AW'(1);
        if (sweep_cnt_r == SWEEP_LAST) begin
          sweep_r <= 1'b0;
        end
      end

      if (!s1_stall) begin
        fwd_vld_r <= mrg_wr;
      end

      if (s1_adv) begin
        case (s1_cmd)
          scgm_pkg::CMD_START: begin
            span_left_r   <= '0;
            span_right_r  <= '0;
            depth_near_r  <= '0;
            depth_far_r   <= '0;
            group_empty_r <= 1'b1;
            cur_fake_r    <= 1'b1;
            if (wrap) begin
              sweep_r     <= 1'b1;
              sweep_cnt_r <= '0;
              epoch_r     <= scgm_pkg::EPOCH_FIRST;
            end else begin
              epoch_r <= epoch_r + scgm_pkg::EPOCH_W'(1);
            end
          end
          scgm_pkg::CMD_SEG: begin
            if (group_empty_r) begin
              span_left_r   <= s1_item_r.seg_left;
              span_right_r  <= s1_item_r.seg_right;
              depth_near_r  <= seg_lo;
              depth_far_r   <= seg_hi;
              group_empty_r <= 1'b0;
            end else begin
              if (s1_item_r.seg_left < span_left_r) begin
                span_left_r <= s1_item_r.seg_left;
              end
              if (s1_item_r.seg_right > span_right_r) begin
                span_right_r <= s1_item_r.seg_right;
              end
              if (seg_lo < depth_near_r) begin
                depth_near_r <= seg_lo;
              end
              if (depth_far_r < seg_hi) begin
                depth_far_r <= seg_hi;
              end
            end
            cur_left_r  <= s1_item_r.seg_left;
            cur_right_r <= s1_item_r.seg_right;
            cur_fake_r  <= s1_item_r.is_fake;
            cur_sil_r   <= s1_item_r.sil_bits;
          end
          default: begin
          end
        endcase
      end

      if (s1_adv && s1_res) begin
        out_vld_r <= 1'b1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_if.data;
    end
    if (mrg_wr) begin
      fwd_addr_r <= s1_addr;
      fwd_ent_r  <= mrg_ent;
    end
    if (s1_adv && s1_res) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign cfg_if.ready = 1'b1;
  assign out_if.valid = out_vld_r;
  assign out_if.data  = out_item_r;

  a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r |-> !in_if.ready)
    else $error("input accepted during clearing sweep");

  a_sweep_stage_empty: assert property (@(posedge clk) disable iff (!rst_n)
    sweep_r |-> !s1_vld_r)
    else $error("stage 1 busy during clearing sweep");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    !sweep_r |-> epoch_r != '0)
    else $error("group tag collides with swept tag");

  a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!rst_n)
    mrg_wr |=> fwd_vld_r && fwd_addr_r == $past(s1_addr))
    else $error("column write not forwarded");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    s1_stall |-> out_vld_r && !out_if.ready)
    else $error("stage 1 stalled without a blocked result");

endmodule
`default_nettype wire

// ----- sv/scgm_col_mem.sv -----
`default_nettype none
// Per-column clip store: one write port, one registered read port.
module scgm_col_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire scgm_pkg::col_ent_t wr_data,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output      scgm_pkg::col_ent_t rd_data
);

  scgm_pkg::col_ent_t mem [DEPTH];
  scgm_pkg::col_ent_t rd_data_r;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ----- dv/sprite_clip_group_merge_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the sprite clip group merge unit with a clocked driver and monitor.
module sprite_clip_group_merge_unit_test;

  localparam int COLUMNS = 2048;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST = 3'd7;

  logic clk;
  logic rst_n;

  scgm_chan_if #(.payload_t(scgm_pkg::in_item_t)) in_ch ();
  scgm_chan_if #(.payload_t(scgm_pkg::out_item_t)) out_ch ();
  scgm_chan_if #(.payload_t(scgm_pkg::cfg_data_t)) cfg_ch ();

  sprite_clip_group_merge_unit #(.MAX_WIDTH(COLUMNS)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Items waiting to be sent and results (group bounds, column reads) still owed by the block.
  scgm_pkg::in_item_t clip_items[$];
  scgm_pkg::out_item_t owed_reports[$];
  int items_queued;
  int errors;
  int cycle_count;
  int send_hold;
  int stall_left;
  bit item_taken;
  bit bursty;

  // Predicted block state.
  logic signed [15:0] merged_top[COLUMNS];
  logic signed [15:0] merged_bottom[COLUMNS];
  bit column_marked[COLUMNS];
  logic [10:0] span_lo;
  logic [11:0] span_hi;
  logic signed [31:0] near_z;
  logic signed [31:0] far_z;
  bit no_segment;
  logic [10:0] seg_lo;
  logic [11:0] seg_hi;
  bit seg_fake;
  logic [1:0] seg_sil;
  logic [14:0] height;

  function automatic void clear_group_model();
    column_marked = '{default: 1'b0};
    span_lo = '0;
    span_hi = '0;
    near_z = '0;
    far_z = '0;
    no_segment = 1'b1;
    // Stray column items after a group start must be dropped.
    seg_fake = 1'b1;
  endfunction

  task automatic predict_item(input scgm_pkg::in_item_t it);
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    scgm_pkg::out_item_t rep;
    rep = '0;
    case (it.cmd)
      scgm_pkg::CMD_START: clear_group_model();
      scgm_pkg::CMD_SEG: begin
        lo = (it.depth_end < it.depth_start) ? it.depth_end : it.depth_start;
        hi = (it.depth_start < it.depth_end) ? it.depth_end : it.depth_start;
        if (no_segment) begin
          span_lo = it.seg_left;
          span_hi = it.seg_right;
          near_z = lo;
          far_z = hi;
          no_segment = 1'b0;
        end else begin
          if (it.seg_left < span_lo) span_lo = it.seg_left;
          if (it.seg_right > span_hi) span_hi = it.seg_right;
          if (lo < near_z) near_z = lo;
          if (far_z < hi) far_z = hi;
        end
        seg_lo = it.seg_left;
        seg_hi = it.seg_right;
        seg_fake = it.is_fake;
        seg_sil = it.sil_bits;
      end
      scgm_pkg::CMD_COL: begin
        if (!(seg_fake || it.column < seg_lo || it.column >= seg_hi
              || it.column >= COLUMNS)) begin
          if (!column_marked[it.column]) begin
            merged_top[it.column] = '0;
            merged_bottom[it.column] = {1'b0, height};
            column_marked[it.column] = 1'b1;
          end
          if (seg_sil[0] && it.col_bottom < merged_bottom[it.column])
            merged_bottom[it.column] = it.col_bottom;
          if (seg_sil[1] && merged_top[it.column] < it.col_top)
            merged_top[it.column] = it.col_top;
        end
      end
      scgm_pkg::CMD_FINISH: begin
        rep.result_kind = scgm_pkg::RES_BOUNDS;
        rep.group_left = span_lo;
        rep.group_right = span_hi;
        rep.near_depth = near_z;
        rep.far_depth = far_z;
        owed_reports.push_back(rep);
      end
      scgm_pkg::CMD_READ: begin
        rep.result_kind = scgm_pkg::RES_COLUMN;
        if (it.column < COLUMNS && column_marked[it.column]) begin
          rep.top_clip = merged_top[it.column];
          rep.bottom_clip = merged_bottom[it.column];
        end else begin
          rep.top_clip = '0;
          rep.bottom_clip = {1'b0, height};
        end
        owed_reports.push_back(rep);
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  task automatic check_report(input scgm_pkg::out_item_t got);
    scgm_pkg::out_item_t want;
    if (owed_reports.size() == 0) begin
      $error("result transfer with no expectation waiting");
      errors++;
    end else begin
      want = owed_reports.pop_front();
      compare_field("result_kind", 32'(want.result_kind), 32'(got.result_kind));
      compare_field("group_left", 32'(want.group_left), 32'(got.group_left));
      compare_field("group_right", 32'(want.group_right), 32'(got.group_right));
      compare_field("near_depth", want.near_depth, got.near_depth);
      compare_field("far_depth", want.far_depth, got.far_depth);
      compare_field("top_clip", 32'(want.top_clip), 32'(got.top_clip));
      compare_field("bottom_clip", 32'(want.bottom_clip), 32'(got.bottom_clip));
    end
  endtask

  // Fields that an item's command does not use are left random.
  function automatic scgm_pkg::in_item_t noise_item();
    scgm_pkg::in_item_t it;
    it.cmd = 3'($urandom_range(int'(scgm_pkg::CMD_START), int'(CMD_SPARE_LAST)));
    it.seg_left = 11'($urandom);
    it.seg_right = 12'($urandom_range(0, COLUMNS));
    it.depth_start = $urandom;
    it.depth_end = $urandom;
    it.is_fake = 1'($urandom);
    it.sil_bits = 2'($urandom);
    it.column = 11'($urandom);
    it.col_top = 16'($urandom);
    it.col_bottom = 16'($urandom);
    return it;
  endfunction

  function automatic scgm_pkg::in_item_t cmd_item(logic [2:0] code, int column);
    scgm_pkg::in_item_t it;
    it = noise_item();
    it.cmd = code;
    it.column = 11'(column);
    return it;
  endfunction

  function automatic scgm_pkg::in_item_t seg_item(int left, int right, logic [31:0] d0,
                                                  logic [31:0] d1, bit fake,
                                                  logic [1:0] sil);
    scgm_pkg::in_item_t it;
    it = noise_item();
    it.cmd = scgm_pkg::CMD_SEG;
    it.seg_left = 11'(left);
    it.seg_right = 12'(right);
    it.depth_start = d0;
    it.depth_end = d1;
    it.is_fake = fake;
    it.sil_bits = sil;
    return it;
  endfunction

  function automatic scgm_pkg::in_item_t col_item(int column, logic [15:0] top,
                                                  logic [15:0] bottom);
    scgm_pkg::in_item_t it;
    it = noise_item();
    it.cmd = scgm_pkg::CMD_COL;
    it.column = 11'(column);
    it.col_top = top;
    it.col_bottom = bottom;
    return it;
  endfunction

  function automatic void post_item(scgm_pkg::in_item_t it);
    clip_items.push_back(it);
    items_queued++;
  endfunction

  // Half are values near a typical view height, so merges often change the column.
  function automatic logic [15:0] clip_value();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom_range(0, 300) - 40);
    endcase
  endfunction

  task automatic queue_directed();
    int code;
    post_item(cmd_item(scgm_pkg::CMD_READ, COLUMNS - 1));
    post_item(cmd_item(scgm_pkg::CMD_FINISH, 0));
    post_item(cmd_item(scgm_pkg::CMD_START, 0));
    post_item(seg_item(0, COLUMNS, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 2'b11));
    post_item(col_item(0, 16'h7FFF, 16'h8000));
    post_item(seg_item(10, 20, 32'hFFFF_0000, 32'h0001_0000, 1'b0, 2'b11));
    post_item(col_item(10, 16'h8000, 16'h7FFF));
    post_item(col_item(10, 16'h7FFF, 16'h8000));
    post_item(col_item(19, 16'd5, 16'd150));
    post_item(col_item(20, 16'd100, 16'd0));
    post_item(cmd_item(scgm_pkg::CMD_READ, 10));
    post_item(cmd_item(scgm_pkg::CMD_READ, 19));
    post_item(seg_item(COLUMNS - 1, COLUMNS, 32'd0, 32'd0, 1'b0, 2'b01));
    post_item(col_item(COLUMNS - 1, 16'd300, 16'hFFFB));
    post_item(seg_item(30, 40, 32'd7, 32'd3, 1'b0, 2'b10));
    post_item(col_item(35, 16'hFFF9, 16'hFFF9));
    post_item(seg_item(50, 50, 32'd1, 32'd2, 1'b0, 2'b11));
    post_item(col_item(50, 16'd9, 16'd9));
    post_item(seg_item(60, 62, 32'd4, 32'd4, 1'b0, 2'b00));
    post_item(col_item(61, 16'd70, 16'd10));
    post_item(seg_item(COLUMNS - 1, 0, 32'd5, 32'd5, 1'b0, 2'b11));
    for (code = CMD_SPARE_FIRST; code <= CMD_SPARE_LAST; code++)
      post_item(cmd_item(3'(code), 35));
    post_item(cmd_item(scgm_pkg::CMD_FINISH, 0));
    post_item(cmd_item(scgm_pkg::CMD_READ, COLUMNS - 1));
    post_item(cmd_item(scgm_pkg::CMD_READ, 35));
    post_item(cmd_item(scgm_pkg::CMD_READ, 61));
  endtask

  // One group: segments clustered around a base column so that they often overlap.
  task automatic queue_group();
    int base;
    int top_col;
    int left;
    int right;
    int width;
    base = $urandom_range(0, COLUMNS - 1);
    top_col = (base + 28 > COLUMNS - 1) ? COLUMNS - 1 : base + 28;
    post_item(cmd_item(scgm_pkg::CMD_START, $urandom_range(0, COLUMNS - 1)));
    repeat ($urandom_range(1, 6)) begin
      left = $urandom_range(base, top_col);
      width = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
      right = (left + width > COLUMNS) ? COLUMNS : left + width;
      if ($urandom_range(0, 11) == 0) right = $urandom_range(0, COLUMNS);
      post_item(seg_item(left, right, $urandom, $urandom, $urandom_range(0, 5) == 0,
                         2'($urandom)));
      repeat ($urandom_range(0, 8)) begin
        if (right > left && $urandom_range(0, 7) != 0)
          post_item(col_item($urandom_range(left, right - 1), clip_value(), clip_value()));
        else
          post_item(col_item($urandom_range(base, top_col), clip_value(), clip_value()));
      end
      if ($urandom_range(0, 2) == 0)
        post_item(cmd_item(scgm_pkg::CMD_READ, $urandom_range(base, top_col)));
    end
    if ($urandom_range(0, 9) != 0)
      post_item(cmd_item(scgm_pkg::CMD_FINISH, $urandom_range(0, COLUMNS - 1)));
    repeat ($urandom_range(0, 3))
      post_item(cmd_item(scgm_pkg::CMD_READ, $urandom_range(base, top_col)));
  endtask

  task automatic queue_random(int count);
    int goal;
    goal = items_queued + count;
    while (items_queued < goal) begin
      if ($urandom_range(0, 9) == 0) post_item(noise_item());
      else queue_group();
    end
  endtask

  // Waits until every item is sent and every report has come back.
  task automatic drain();
    do @(posedge clk);
    while (clip_items.size() != 0 || in_ch.valid || owed_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_height(logic [14:0] value);
    @(negedge clk);
    cfg_ch.data <= value;
    cfg_ch.valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ch.ready);
    height = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Item driver: holds an item until its transfer, then moves on or idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      item_taken = 1'b0;
    end else if (!in_ch.valid || item_taken) begin
      item_taken = 1'b0;
      if (send_hold > 0) begin
        send_hold--;
        in_ch.valid <= 1'b0;
      end else if (clip_items.size() != 0) begin
        in_ch.data <= clip_items.pop_front();
        in_ch.valid <= 1'b1;
        if (bursty && $urandom_range(0, 7) == 0) send_hold = $urandom_range(1, 13);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if (bursty && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 13);
    end
  end

  // Monitor: checks result transfers and feeds accepted items to the predictor.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      if (rst_n && out_ch.valid && out_ch.ready) check_report(out_ch.data);
      if (rst_n && in_ch.valid && in_ch.ready) begin
        predict_item(in_ch.data);
        item_taken = 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    bursty = 1'b1;
    clear_group_model();
    seg_lo = '0;
    seg_hi = '0;
    seg_sil = '0;
    height = scgm_pkg::VIEW_HEIGHT_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_directed();
    drain();
    set_height('0);
    queue_random(205);
    drain();
    set_height('1);
    queue_random(205);
    drain();
    set_height(15'($urandom_range(1, 32766)));
    queue_random(205);
    drain();
    // The last part runs at full rate on both sides.
    bursty = 1'b0;
    send_hold = 0;
    stall_left = 0;
    set_height(scgm_pkg::VIEW_HEIGHT_RST);
    queue_random(205);
    drain();

    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- sprite_clip_group_merge_unit.f -----
sv/scgm_pkg.sv
sv/scgm_chan_if.sv
sv/scgm_col_mem.sv
sv/sprite_clip_group_merge_unit.sv
dv/sprite_clip_group_merge_unit_test.sv
